@@ rtl/core/b64d_pkg.sv @@
// Package for the streaming Base64 decoder: character classes, phase codes
// and the result bundle passed from the decode stage to the output stage.
// No dependencies.
package b64d_pkg;

  // Character classes; values 0 to 63 are the sextet itself.
  localparam logic [7:0] CL_PAD  = 8'h80;
  localparam logic [7:0] CL_WS   = 8'hE0;
  localparam logic [7:0] CL_LF   = 8'hF0;
  localparam logic [7:0] CL_CR   = 8'hF1;
  localparam logic [7:0] CL_DASH = 8'hF2;
  localparam logic [7:0] CL_BAD  = 8'hFF;

  // A class is trimmable when OR-ing the mask gives the match value.
  localparam logic [7:0] TRIM_MASK  = 8'h13;
  localparam logic [7:0] TRIM_MATCH = 8'hF3;

  // Width of the status byte count on the output channel.
  localparam int TOTAL_BITS = 24;

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_DATA = 2'd1,
    PH_TAIL = 2'd2
  } b64d_phase_t;

  // Results caused by one input character: up to three bytes, then a status.
  typedef struct packed {
    logic [1:0]            byte_count;
    logic [2:0][7:0]       bytes;
    logic                  status;
    logic                  failed;
    logic [TOTAL_BITS-1:0] total;
  } b64d_bundle_t;

  // Map a 7-bit ASCII character to its class.
  function automatic logic [7:0] b64d_classify(input logic [7:0] c);
    logic [7:0] cls;
    cls = CL_BAD;
    if (c >= 8'h41 && c <= 8'h5A) begin
      cls = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      cls = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cls = c - 8'h30 + 8'd52;
    end else begin
      case (c)
        8'h2B:        cls = 8'd62;
        8'h2F:        cls = 8'd63;
        8'h3D:        cls = CL_PAD;
        8'h09, 8'h20: cls = CL_WS;
        8'h0A:        cls = CL_LF;
        8'h0D:        cls = CL_CR;
        8'h2D:        cls = CL_DASH;
        default:      cls = CL_BAD;
      endcase
    end
    return cls;
  endfunction

endpackage

@@ rtl/core/b64d_if.sv @@
// Channel interfaces of the Base64 decoder: character input and result output.
// Depends on b64d_pkg for the byte count width.
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface b64d_out_if import b64d_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [7:0]            data_byte;
  logic                  is_status;
  logic                  failed;
  logic [TOTAL_BITS-1:0] byte_total;
  logic                  last_result;

  modport source (output valid, output data_byte, output is_status, output failed,
                  output byte_total, output last_result, input ready);
  modport sink (input valid, input data_byte, input is_status, input failed,
                input byte_total, input last_result, output ready);
endinterface

@@ rtl/core/b64d_core.sv @@
// Decode stage: classifies one accepted character, updates the decoder state
// and forms the bundle of results it causes. Depends on b64d_pkg.
module b64d_core import b64d_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  logic [7:0]   char_code,
  input  logic         end_of_text,
  output b64d_bundle_t bundle
);

  localparam int CW = (COUNT_BITS > TOTAL_BITS) ? TOTAL_BITS : COUNT_BITS;
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] CAP = {CW{1'b1}};

  // Decoder state.
  b64d_phase_t   phase, phase_next;
  logic [17:0]   held_sextets, held_sextets_next;
  logic [1:0]    group_slot, group_slot_next;
  logic [1:0]    kept_len_mod4, kept_len_mod4_next;
  logic          kept_len_big, kept_len_big_next;
  logic [2:0]    trailing_run, trailing_run_next;
  logic          error_seen, error_seen_next;
  logic [CW-1:0] bytes_out, bytes_out_next;
  logic          last_high, last_high_next;

  // Per-character decisions.
  logic [7:0] cls;
  logic       high, trim, is_ws, is_pad, is_sext;
  logic       lead_skip, eff_data, eff_tail;
  logic       d_keep, pad_ok, pad_err, grp_emit, sext_shift, bad_err;
  logic       do_keep, do_trim, set_err;
  logic [1:0] n_bytes;
  logic [2:0] keep_sum;
  logic [23:0] word;
  logic [SW-1:0] cnt_sum;
  logic       ok;

  // Classify the character and decide what it does.
  always_comb begin
    cls       = b64d_classify(char_code);
    high      = char_code[7];
    trim      = !high && ((cls | TRIM_MASK) == TRIM_MATCH);
    is_ws     = !high && (cls == CL_WS);
    is_pad    = cls == CL_PAD;
    is_sext   = cls[7:6] == 2'b00;
    lead_skip = (phase == PH_LEAD) && is_ws;
    eff_data  = !error_seen && !lead_skip && (phase == PH_LEAD || phase == PH_DATA);
    eff_tail  = !error_seen && (phase == PH_TAIL);

    d_keep     = eff_data && !high && !trim && (trailing_run == 3'd0);
    pad_ok     = d_keep && is_pad && group_slot[1];
    pad_err    = d_keep && is_pad && !group_slot[1];
    grp_emit   = d_keep && !high && is_sext && (group_slot == 2'd3);
    sext_shift = d_keep && !high && is_sext && (group_slot != 2'd3);
    bad_err    = d_keep && !is_pad && !is_sext;

    do_keep = d_keep || (eff_tail && !trim);
    do_trim = (eff_data || eff_tail) && trim;
    set_err = pad_err || bad_err ||
              (eff_data && (high || (!trim && trailing_run != 3'd0)));

    if (grp_emit) begin
      n_bytes = 2'd3;
    end else if (pad_ok) begin
      n_bytes = group_slot[0] ? 2'd2 : 2'd1;
    end else begin
      n_bytes = 2'd0;
    end

    keep_sum = {1'b0, kept_len_mod4} + {1'b0, trailing_run[1:0]} + 3'd1;
    word     = {held_sextets, cls[5:0]};
    cnt_sum  = {1'b0, bytes_out} + SW'(n_bytes);
  end

  // Next state; the state registers return to reset after the end mark.
  always_comb begin
    phase_next         = phase;
    held_sextets_next  = held_sextets;
    group_slot_next    = group_slot;
    kept_len_mod4_next = kept_len_mod4;
    kept_len_big_next  = kept_len_big;
    trailing_run_next  = trailing_run;
    error_seen_next    = error_seen || set_err;
    last_high_next     = last_high;
    bytes_out_next     = (cnt_sum > {1'b0, CAP}) ? CAP : cnt_sum[CW-1:0];

    if (phase == PH_LEAD && !error_seen && !lead_skip) begin
      phase_next = PH_DATA;
    end
    if (pad_ok) begin
      phase_next = PH_TAIL;
    end
    if (do_keep) begin
      kept_len_big_next  = kept_len_big || trailing_run[2] || keep_sum[2];
      kept_len_mod4_next = keep_sum[1:0];
      trailing_run_next  = 3'd0;
    end
    if (do_trim) begin
      trailing_run_next = {1'b1, trailing_run[1:0] + 2'd1};
    end
    if (eff_tail && !trim) begin
      last_high_next = high;
    end
    if (grp_emit) begin
      held_sextets_next = '0;
      group_slot_next   = 2'd0;
    end else if (sext_shift) begin
      held_sextets_next = {held_sextets[11:0], cls[5:0]};
      group_slot_next   = group_slot + 2'd1;
    end
  end

  // Result bundle; the status uses the state after this character.
  always_comb begin
    if (error_seen_next) begin
      ok = 1'b0;
    end else if (kept_len_big_next) begin
      ok = (kept_len_mod4_next == 2'd0) && !last_high_next;
    end else begin
      ok = (kept_len_mod4_next == 2'd0) && (trailing_run_next == 3'd0);
    end

    bundle.byte_count = n_bytes;
    if (grp_emit) begin
      bundle.bytes = {word[7:0], word[15:8], word[23:16]};
    end else if (group_slot[0]) begin
      bundle.bytes = {8'h00, held_sextets[9:2], held_sextets[17:10]};
    end else begin
      bundle.bytes = {8'h00, 8'h00, held_sextets[11:4]};
    end
    bundle.status = end_of_text;
    bundle.failed = !ok;
    bundle.total  = ok ? TOTAL_BITS'(bytes_out_next) : '0;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      held_sextets  <= '0;
      group_slot    <= 2'd0;
      kept_len_mod4 <= 2'd0;
      kept_len_big  <= 1'b0;
      trailing_run  <= 3'd0;
      error_seen    <= 1'b0;
      bytes_out     <= '0;
      last_high     <= 1'b0;
    end else if (fire) begin
      if (end_of_text) begin
        phase         <= PH_LEAD;
        held_sextets  <= '0;
        group_slot    <= 2'd0;
        kept_len_mod4 <= 2'd0;
        kept_len_big  <= 1'b0;
        trailing_run  <= 3'd0;
        error_seen    <= 1'b0;
        bytes_out     <= '0;
        last_high     <= 1'b0;
      end else begin
        phase         <= phase_next;
        held_sextets  <= held_sextets_next;
        group_slot    <= group_slot_next;
        kept_len_mod4 <= kept_len_mod4_next;
        kept_len_big  <= kept_len_big_next;
        trailing_run  <= trailing_run_next;
        error_seen    <= error_seen_next;
        bytes_out     <= bytes_out_next;
        last_high     <= last_high_next;
      end
    end
  end

endmodule

@@ rtl/core/b64d_emit.sv @@
// Output stage: holds the results of one character in registers and sends
// them one request at a time, bytes first, then the status. Depends on
// b64d_pkg and b64d_out_if.
module b64d_emit import b64d_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  b64d_bundle_t      bundle,
  output logic              can_load,
  b64d_out_if.source        out_ch
);

  logic [2:0][7:0]       byte_q;
  logic [1:0]            byte_left;
  logic                  stat_pend;
  logic                  stat_failed;
  logic [TOTAL_BITS-1:0] stat_total;
  logic                  pop, last_one, sending_status;

  // Handshake and load condition: the stage can take a new bundle once the
  // request it is sending now is its last one.
  always_comb begin
    out_ch.valid   = (byte_left != 2'd0) || stat_pend;
    pop            = out_ch.valid && out_ch.ready;
    last_one       = ((byte_left == 2'd1) && !stat_pend) ||
                     ((byte_left == 2'd0) && stat_pend);
    can_load       = !out_ch.valid || (pop && last_one);
    sending_status = byte_left == 2'd0;
  end

  // Output payload.
  always_comb begin
    out_ch.data_byte   = sending_status ? 8'h00 : byte_q[0];
    out_ch.is_status   = sending_status;
    out_ch.failed      = sending_status && stat_failed;
    out_ch.byte_total  = sending_status ? stat_total : '0;
    out_ch.last_result = sending_status;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_left <= 2'd0;
      stat_pend <= 1'b0;
    end else if (load) begin
      byte_left <= bundle.byte_count;
      stat_pend <= bundle.status;
    end else if (pop) begin
      if (!sending_status) begin
        byte_left <= byte_left - 2'd1;
      end else begin
        stat_pend <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_q      <= bundle.bytes;
      stat_failed <= bundle.failed;
      stat_total  <= bundle.total;
    end else if (pop && !sending_status) begin
      byte_q <= {8'h00, byte_q[2:1]};
    end
  end

endmodule

@@ rtl/core/base64_stream_decoder_unit.sv @@
// Top level of the streaming Base64 decoder: decode stage and output stage.
// Depends on b64d_pkg, b64d_if, b64d_core and b64d_emit.
//
//   channel  direction  payload
//   in_ch    sink       char_code[7:0], end_of_text
//   out_ch   source     data_byte[7:0], is_status, failed, byte_total[23:0],
//                       last_result
//
// One character is taken per cycle while the output register is empty or is
// sending its last pending result. The first result of a character is valid
// in the cycle after it is accepted. A character that causes more than one
// result (a full group, a pad that releases two bytes, or bytes plus the end
// mark) holds the input until its last result is being sent, so throughput is set
// by the single output register.
// Reset (rst, synchronous) returns the decoder to the start of a text and
// drops pending results. A stall on out_ch while a result is pending holds
// in_ch.ready low.
module base64_stream_decoder_unit import b64d_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  b64d_in_if.sink     in_ch,
  b64d_out_if.source  out_ch
);

  b64d_bundle_t bundle;
  logic         can_load;
  logic         fire;

  // Input handshake.
  assign in_ch.ready = can_load;
  assign fire        = in_ch.valid && can_load;

  b64d_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .char_code   (in_ch.char_code),
    .end_of_text (in_ch.end_of_text),
    .bundle      (bundle)
  );

  b64d_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .bundle   (bundle),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule
